[rtl/round_robin_quantum_scheduler_top_macros.svh]
// assertion macros for the round-robin scheduler top level
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define RRQS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RRQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rrqs_pkg.sv]
// shared types and codes for the round-robin scheduler
package rrqs_pkg;

    localparam int REQ_W      = 3;
    localparam int TASK_ID_W  = 4;
    localparam int PRIO_W     = 8;
    localparam int STATUS_W   = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SETPRIO = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SETBLK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_KILL    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_TASK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // slots that may never be killed
    localparam logic [TASK_ID_W-1:0] IDLE_ID  = 4'd0;
    localparam logic [TASK_ID_W-1:0] FIRST_ID = 4'd1;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [TASK_ID_W-1:0] task_id;
        logic [PRIO_W-1:0]    priority_value;
        logic                 blocked;
    } in_t;

    typedef struct packed {
        logic [TASK_ID_W-1:0] current_task;
        logic                 switched;
        logic [STATUS_W-1:0]  status;
        logic [TASK_ID_W-1:0] new_task_id;
    } out_t;

    // one slot table entry: priority and remaining ticks
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [PRIO_W-1:0] count;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

[rtl/round_robin_quantum_scheduler_top.sv]
// top level of the round-robin time-slice scheduler
//
// Requests come in on in_valid/in_ready/in_data, one result beat per request
// goes out on out_valid/out_ready/out_data. cfg_we with cfg_wdata writes
// sched_enable; the user must write it only while the block is idle, and the
// block itself does not enforce this. A request is taken in the idle state,
// the slot table entry of the running task is read from the table ram in that
// cycle and the request is worked out in the execute state from the ram's
// registered read data, writing the result into the output register; no new
// request is taken before the block is back in idle. in_ready rises again once
// the result sits there, so a new request is taken while the old result waits.
// If the receiver stalls and the output register is still full, the block
// holds its finished request in the execute state until the beat is taken.
// Reset (rst_n, asynchronous, active low) makes slot 0, the idle task, the
// only live slot and running, sets next free id to 1 and clears the enable.
// The slot table needs no clearing pass: per-entry valid bits, cleared at
// reset, make an unwritten entry read as zero priority and counter.
`include "round_robin_quantum_scheduler_top_macros.svh"

module round_robin_quantum_scheduler_top
    import rrqs_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int ID_W   = $clog2(MAX_TASKS + 1);
    localparam int CMP_W  = (ID_W > TASK_ID_W) ? ID_W : TASK_ID_W;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0]           state_reg, state_next;
    logic                 sched_enable_reg;
    logic [SLOT_W-1:0]    running_slot_reg, running_slot_next;
    logic [MAX_TASKS-1:0] live_mask_reg, live_mask_next;
    logic [MAX_TASKS-1:0] blocked_mask_reg, blocked_mask_next;
    logic [MAX_TASKS-1:0] entry_valid_reg, entry_valid_next;
    logic [ID_W-1:0]      next_free_reg, next_free_next;
    logic                 kill_pending_reg, kill_pending_next;
    logic                 rd_valid_reg;
    in_t                  req_reg;
    logic                 out_valid_reg, out_valid_next;
    out_t                 out_data_reg, out_data_next;

    logic                 in_accept;
    logic                 can_finish;
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    slot_entry_t          ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    slot_entry_t          entry_rd;
    logic [SLOT_W-1:0]    pick_from;
    logic [SLOT_W-1:0]    pick_slot;
    logic [SLOT_W-1:0]    tid_slot;
    logic                 tid_in_range;
    logic                 tid_live;
    logic                 tid_below_next;
    logic [PRIO_W-1:0]    prio_eff;
    logic                 search;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign can_finish = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // slot table: priority and counter of every slot
    rrqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (running_slot_reg),
        .rdata (ram_rdata)
    );

    // unwritten entries read as zero
    assign entry_rd = rd_valid_reg ? slot_entry_t'(ram_rdata) : '0;

    // next ready slot, from slot 0 after a kill
    assign pick_from = kill_pending_reg ? '0 : running_slot_reg;

    rrqs_pick #(
        .N (MAX_TASKS)
    ) u_pick (
        .ready_mask (live_mask_reg & ~blocked_mask_reg),
        .from       (pick_from),
        .slot       (pick_slot)
    );

    // addressed slot checks
    assign tid_slot       = SLOT_W'(req_reg.task_id);
    assign tid_in_range   = CMP_W'(req_reg.task_id) < CMP_W'(MAX_TASKS);
    assign tid_live       = tid_in_range && live_mask_reg[tid_slot];
    assign tid_below_next = CMP_W'(req_reg.task_id) < CMP_W'(next_free_reg);
    assign prio_eff       = (req_reg.priority_value == '0) ? PRIO_W'(1)
                                                          : req_reg.priority_value;

    // request execution
    always_comb
    begin
        state_next        = state_reg;
        running_slot_next = running_slot_reg;
        live_mask_next    = live_mask_reg;
        blocked_mask_next = blocked_mask_reg;
        entry_valid_next  = entry_valid_reg;
        next_free_next    = next_free_reg;
        kill_pending_next = kill_pending_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_data_next     = out_data_reg;
        ram_we            = 1'b0;
        ram_waddr         = running_slot_reg;
        ram_wdata         = entry_rd;
        search            = 1'b0;

        if (in_accept)
        begin
            state_next = S_EXEC;
        end

        if (state_reg == S_EXEC && can_finish)
        begin
            state_next                 = S_IDLE;
            out_valid_next             = 1'b1;
            out_data_next.switched     = 1'b0;
            out_data_next.status       = ST_OK;
            out_data_next.new_task_id  = '0;

            case (req_reg.req_type)
                REQ_TICK:
                begin
                    if (sched_enable_reg)
                    begin
                        if (kill_pending_reg)
                        begin
                            kill_pending_next = 1'b0;
                            search            = 1'b1;
                        end
                        else if (entry_rd.count != '0)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.prio  = entry_rd.prio;
                            ram_wdata.count = entry_rd.count - PRIO_W'(1);
                            entry_valid_next[running_slot_reg] = 1'b1;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.prio  = entry_rd.prio;
                            ram_wdata.count = entry_rd.prio;
                            entry_valid_next[running_slot_reg] = 1'b1;
                            search          = 1'b1;
                        end
                        if (search)
                        begin
                            running_slot_next      = pick_slot;
                            out_data_next.switched = (pick_slot != running_slot_reg);
                        end
                    end
                end
                REQ_ADD:
                begin
                    if (next_free_reg >= ID_W'(MAX_TASKS))
                    begin
                        out_data_next.status = ST_FULL;
                    end
                    else
                    begin
                        live_mask_next[SLOT_W'(next_free_reg)]    = 1'b1;
                        blocked_mask_next[SLOT_W'(next_free_reg)] = 1'b0;
                        entry_valid_next[SLOT_W'(next_free_reg)]  = 1'b0;
                        next_free_next            = next_free_reg + ID_W'(1);
                        out_data_next.new_task_id = TASK_ID_W'(next_free_reg);
                    end
                end
                REQ_SETPRIO:
                begin
                    if (!tid_below_next || !tid_live)
                    begin
                        out_data_next.status = ST_NO_TASK;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = tid_slot;
                        ram_wdata.prio  = prio_eff;
                        ram_wdata.count = prio_eff;
                        entry_valid_next[tid_slot] = 1'b1;
                    end
                end
                REQ_SETBLK:
                begin
                    if (!tid_live)
                    begin
                        out_data_next.status = ST_NO_TASK;
                    end
                    else
                    begin
                        blocked_mask_next[tid_slot] = req_reg.blocked;
                    end
                end
                REQ_KILL:
                begin
                    if (req_reg.task_id == IDLE_ID || req_reg.task_id == FIRST_ID)
                    begin
                        out_data_next.status = ST_REFUSED;
                    end
                    else if (!tid_live)
                    begin
                        out_data_next.status = ST_NO_TASK;
                    end
                    else
                    begin
                        live_mask_next[tid_slot]    = 1'b0;
                        blocked_mask_next[tid_slot] = 1'b0;
                        entry_valid_next[tid_slot]  = 1'b0;
                        kill_pending_next           = 1'b1;
                    end
                end
                default:
                begin
                    out_data_next.status = ST_OK;
                end
            endcase

            out_data_next.current_task = TASK_ID_W'(running_slot_next);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sched_enable_reg <= 1'b0;
            running_slot_reg <= '0;
            live_mask_reg    <= MAX_TASKS'(1);
            blocked_mask_reg <= '0;
            entry_valid_reg  <= '0;
            next_free_reg    <= ID_W'(1);
            kill_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            running_slot_reg <= running_slot_next;
            live_mask_reg    <= live_mask_next;
            blocked_mask_reg <= blocked_mask_next;
            entry_valid_reg  <= entry_valid_next;
            next_free_reg    <= next_free_next;
            kill_pending_reg <= kill_pending_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                sched_enable_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg      <= in_data;
            rd_valid_reg <= entry_valid_reg[running_slot_reg];
        end
        out_data_reg <= out_data_next;
    end

    // checks
    `RRQS_ASSERT_NEXT(a_one_at_a_time, in_accept, !in_ready,
        "request accepted while the previous one is still executing")
    `RRQS_ASSERT_NEXT(a_hold_on_stall,
        state_reg == S_EXEC && out_valid_reg && !out_ready,
        state_reg == S_EXEC && out_valid_reg,
        "finished request dropped while the output beat was stalled")
    `RRQS_ASSERT_NOW(a_table_sane, 1'b1,
        live_mask_reg[0] && next_free_reg <= ID_W'(MAX_TASKS),
        "idle slot lost or next free id beyond the table")
    `RRQS_ASSERT_NOW(a_switch_ok, out_valid_reg && out_data_reg.switched,
        out_data_reg.status == ST_OK && out_data_reg.new_task_id == '0,
        "switch reported with a non-tick result")

endmodule

[rtl/rrqs_ram.sv]
// generic single-write, single-read ram with registered read data
module rrqs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/rrqs_pick.sv]
// round-robin search for the next ready slot after a given one
module rrqs_pick #(
    parameter int N = 16
) (
    input  logic [N-1:0]         ready_mask,
    input  logic [$clog2(N)-1:0] from,
    output logic [$clog2(N)-1:0] slot
);

    localparam int SLOT_W = $clog2(N);

    logic [2*N-1:0]    dbl;
    logic [SLOT_W:0]   start;
    logic [2*N-1:0]    shifted;
    logic [N-1:0]      window;
    logic              hit;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W:0]   sum;

    // rotate so the slot after from sits at bit 0, from itself last
    assign dbl     = {ready_mask, ready_mask};
    assign start   = (SLOT_W+1)'(from) + (SLOT_W+1)'(1);
    assign shifted = dbl >> start;
    assign window  = shifted[N-1:0];

    // lowest set bit of the rotated window
    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        for (int j = N - 1; j >= 0; j--)
        begin
            if (window[j])
            begin
                hit = 1'b1;
                idx = SLOT_W'(j);
            end
        end
    end

    // undo the rotation, fall back to the idle slot
    always_comb
    begin
        sum = start + (SLOT_W+1)'(idx);
        if (sum >= (SLOT_W+1)'(N))
        begin
            sum = sum - (SLOT_W+1)'(N);
        end
        slot = hit ? sum[SLOT_W-1:0] : '0;
    end

endmodule
